// ===== hdl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed shift list package
// Shared types, request and status codes, and sizing helpers for the
// indexed shift list and its cell chain.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int FUNC_W        = 3;
  localparam int INDEX_W       = 11;
  localparam int COUNT_W       = 11;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 1024;
  localparam int GATHER_FANIN  = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT_AT  = 3'd0,
    FN_REMOVE_AT  = 3'd1,
    FN_READ_AT    = 3'd2,
    FN_PUSH_FRONT = 3'd3,
    FN_PUSH_BACK  = 3'd4,
    FN_POP_FRONT  = 3'd5,
    FN_POP_BACK   = 3'd6,
    FN_CLEAR      = 3'd7
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_GATHER = 1'b1
  } state_e;

  typedef struct packed {
    logic signed [31:0] weight;
    logic        [7:0]  color;
    logic signed [31:0] charge;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    func_e                func;
    logic [INDEX_W-1:0]   entry_index;
    logic signed [31:0]   entry_weight;
    logic        [7:0]    entry_color;
    logic signed [31:0]   entry_charge;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic signed [31:0]   out_weight;
    logic        [7:0]    out_color;
    logic signed [31:0]   out_charge;
    logic [COUNT_W-1:0]   list_count;
  } out_t;

  // Command that the sequencer broadcasts to every cell of the chain.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

  // Number of registered levels in the read-back tree for a given depth.
  function automatic int gather_levels(int depth);
    int n;
    int lv;
    n  = depth;
    lv = 0;
    while (n > 1) begin
      n  = (n + GATHER_FANIN - 1) / GATHER_FANIN;
      lv = lv + 1;
    end
    if (lv < 1) lv = 1;
    return lv;
  endfunction

endpackage

// ===== hdl/isl_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed shift list cell
// Holds one list entry. On an insert it takes its lower neighbor's entry
// or the new entry; on a remove it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module isl_cell import isl_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk_i,
  input  cell_cmd_t     cmd_i,
  input  logic [AW-1:0] pos_i,
  input  logic [AW-1:0] cell_idx_i,
  input  entry_t        new_entry_i,
  input  entry_t        lower_i,
  input  entry_t        upper_i,
  output entry_t        entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift_up) begin
      if (cell_idx_i == pos_i) begin
        entry_d = new_entry_i;
      end else if (cell_idx_i > pos_i) begin
        entry_d = lower_i;
      end
    end else if (cmd_i.shift_down && (cell_idx_i >= pos_i)) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hdl/isl_gather.sv =====
// ----------------------------------------------------------------------------
// Indexed shift list read-back tree
// Picks the entry of the cell at the given position through a registered
// OR tree; only the addressed cell drives a nonzero leaf.
// ----------------------------------------------------------------------------
module isl_gather import isl_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEFAULT,
  parameter int AW     = $clog2(DEPTH),
  parameter int LEVELS = gather_levels(DEPTH)
) (
  input  logic          clk_i,
  input  logic [AW-1:0] pos_i,
  input  entry_t        cell_data_i [DEPTH],
  output entry_t        root_o
);

  function automatic int lvl_size(int k);
    int n;
    n = DEPTH;
    for (int m = 0; m < k; m++) begin
      n = (n + GATHER_FANIN - 1) / GATHER_FANIN;
    end
    return n;
  endfunction

  // Offset of level k (k >= 1) inside the flat node array.
  function automatic int lvl_ofs(int k);
    int s;
    s = 0;
    for (int m = 1; m < k; m++) begin
      s = s + lvl_size(m);
    end
    return s;
  endfunction

  localparam int NODES = lvl_ofs(LEVELS + 1);

  logic [ENTRY_W-1:0] leaf   [DEPTH];
  logic [ENTRY_W-1:0] node_q [NODES];

  for (genvar i = 0; i < DEPTH; i++) begin : g_leaf
    assign leaf[i] = (pos_i == AW'(i)) ? cell_data_i[i] : '0;
  end

  for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
    localparam int NN   = lvl_size(k);
    localparam int NP   = lvl_size(k - 1);
    localparam int OFS  = lvl_ofs(k);
    for (genvar j = 0; j < NN; j++) begin : g_node
      localparam int NC = ((NP - j * GATHER_FANIN) < GATHER_FANIN) ?
                          (NP - j * GATHER_FANIN) : GATHER_FANIN;
      logic [ENTRY_W-1:0] acc;
      if (k == 1) begin : g_from_leaf
        always_comb begin
          acc = '0;
          for (int c = 0; c < NC; c++) begin
            acc = acc | leaf[j * GATHER_FANIN + c];
          end
        end
      end else begin : g_from_node
        localparam int POFS = lvl_ofs(k - 1);
        always_comb begin
          acc = '0;
          for (int c = 0; c < NC; c++) begin
            acc = acc | node_q[POFS + j * GATHER_FANIN + c];
          end
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[OFS + j] <= acc;
      end
    end
  end

  assign root_o = node_q[NODES - 1];

endmodule

// ===== hdl/indexed_shift_list_core.sv =====
// ----------------------------------------------------------------------------
// Indexed shift list core
// Ordered list of up to DEPTH entries held in a chain of cells, with
// indexed insert, remove and read, push and pop at both ends, and clear.
// ----------------------------------------------------------------------------
// Usage: a request transaction on in_valid_i/in_stall_o carries the function
// code, an index and the entry to store. Each request yields exactly one
// result transaction on out_valid_o/out_stall_i with a status, the entry read
// or removed (zero otherwise) and the list count after the request.
// The block takes one request at a time. After acceptance, the addressed
// cell's entry climbs a registered OR tree of fan-in 16 with
// L = ceil(log16(DEPTH)) levels (3 at DEPTH 1024); the cells then shift
// as the result is registered, and only then is a new request taken.
// in_stall_o is high while a request is in work. A finished result waits in
// the output register; the next request is still accepted, and its
// completion holds until the waiting result is taken.
// Reset empties the list and drops any pending result; entry contents are
// not cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_shift_list_core import isl_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WW     = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
  localparam int LEVELS = gather_levels(DEPTH);
  localparam int LW     = $clog2(LEVELS + 1);

  state_e         state_q, state_d;
  logic [LW-1:0]  gcnt_q, gcnt_d;
  logic [CW-1:0]  count_q;
  logic [CW-1:0]  new_count_q, new_count_d;
  op_e            op_q, op_d;
  status_e        status_q, status_d;
  logic [AW-1:0]  pos_q;
  logic [WW-1:0]  pos_w;
  entry_t         entry_q;
  logic           out_valid_q;
  out_t           out_data_q, out_data_d;

  logic           accept;
  logic           slot_free;
  logic           commit;
  cell_cmd_t      cmd;
  entry_t         root;
  entry_t         cell_data [DEPTH];

  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = (state_q == S_IDLE) && in_valid_i;
  assign commit    = (state_q == S_GATHER) && (gcnt_q == LW'(LEVELS)) && slot_free;

  // Request decode against the current count.
  always_comb begin
    logic [WW-1:0] idx_w;
    logic [WW-1:0] cnt_w;
    idx_w       = WW'(in_data_i.entry_index);
    cnt_w       = WW'(count_q);
    pos_w       = '0;
    op_d        = OP_NONE;
    status_d    = ST_OK;
    new_count_d = count_q;
    case (in_data_i.func)
      FN_INSERT_AT: begin
        op_d  = OP_INSERT;
        pos_w = idx_w;
      end
      FN_REMOVE_AT: begin
        op_d  = OP_REMOVE;
        pos_w = idx_w;
      end
      FN_READ_AT: begin
        op_d  = OP_READ;
        pos_w = idx_w;
      end
      FN_PUSH_FRONT: op_d = OP_INSERT;
      FN_PUSH_BACK: begin
        op_d  = OP_INSERT;
        pos_w = cnt_w;
      end
      FN_POP_FRONT: op_d = OP_REMOVE;
      FN_POP_BACK: begin
        op_d  = OP_REMOVE;
        pos_w = cnt_w - WW'(1);
      end
      FN_CLEAR: new_count_d = '0;
      default: op_d = OP_NONE;
    endcase
    case (op_d)
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          status_d = ST_BAD;
        end else if (cnt_w >= WW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          new_count_d = count_q + CW'(1);
        end
      end
      OP_REMOVE, OP_READ: begin
        if ((cnt_w == '0) || (pos_w >= cnt_w)) begin
          status_d = ST_BAD;
        end else if (op_d == OP_REMOVE) begin
          new_count_d = count_q - CW'(1);
        end
      end
      default: status_d = ST_OK;
    endcase
    // A failed request changes nothing.
    if (status_d != ST_OK) begin
      op_d = OP_NONE;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_GATHER;
      S_GATHER: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    gcnt_d     = gcnt_q;
    cmd        = '0;
    out_data_d = out_data_q;
    case (state_q)
      S_IDLE: gcnt_d = '0;
      S_GATHER: begin
        if (gcnt_q != LW'(LEVELS)) begin
          gcnt_d = gcnt_q + LW'(1);
        end
        if (commit) begin
          cmd.shift_up   = (op_q == OP_INSERT);
          cmd.shift_down = (op_q == OP_REMOVE);
          out_data_d.status     = status_q;
          out_data_d.list_count = COUNT_W'(new_count_q);
          if ((op_q == OP_READ) || (op_q == OP_REMOVE)) begin
            out_data_d.out_weight = root.weight;
            out_data_d.out_color  = root.color;
            out_data_d.out_charge = root.charge;
          end else begin
            out_data_d.out_weight = '0;
            out_data_d.out_color  = '0;
            out_data_d.out_charge = '0;
          end
        end
      end
      default: gcnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gcnt_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      gcnt_q  <= gcnt_d;
      if (commit) begin
        count_q     <= new_count_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      op_q           <= op_d;
      status_q       <= status_d;
      new_count_q    <= new_count_d;
      pos_q          <= AW'(pos_w);
      entry_q.weight <= in_data_i.entry_weight;
      entry_q.color  <= in_data_i.entry_color;
      entry_q.charge <= in_data_i.entry_charge;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t lower;
    entry_t upper;
    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[i - 1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign upper = cell_data[i];
    end else begin : g_upper
      assign upper = cell_data[i + 1];
    end
    isl_cell #(
      .AW (AW)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (pos_q),
      .cell_idx_i  (AW'(i)),
      .new_entry_i (entry_q),
      .lower_i     (lower),
      .upper_i     (upper),
      .entry_o     (cell_data[i])
    );
  end

  isl_gather #(
    .DEPTH  (DEPTH),
    .AW     (AW),
    .LEVELS (LEVELS)
  ) u_gather (
    .clk_i       (clk_i),
    .pos_i       (pos_q),
    .cell_data_i (cell_data),
    .root_o      (root)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== bench/isl_list_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed shift list checker
// Watches the request and result channels of the indexed shift list, keeps
// its own copy of the list, works out the result of every accepted request
// and compares each accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module isl_list_checker import isl_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   list_len_o
);

  localparam int PEND_DEPTH = 8;

  entry_t list_mem [DEPTH];
  int     list_len;
  out_t   pend_mem [PEND_DEPTH];
  int     pend_rd;
  int     pend_wr;
  int     pend_cnt;
  out_t   oldest_result;
  out_t   new_result;

  task automatic apply_list_request(input in_t req, output out_t res);
    int pos;
    int i;
    bit grows;
    bit shrinks;
    bit peeks;
    res     = '0;
    pos     = 0;
    grows   = 1'b0;
    shrinks = 1'b0;
    peeks   = 1'b0;
    case (req.func)
      FN_INSERT_AT: begin
        pos   = int'(req.entry_index);
        grows = 1'b1;
      end
      FN_REMOVE_AT: begin
        pos     = int'(req.entry_index);
        shrinks = 1'b1;
      end
      FN_READ_AT: begin
        pos   = int'(req.entry_index);
        peeks = 1'b1;
      end
      FN_PUSH_FRONT: grows = 1'b1;
      FN_PUSH_BACK: begin
        pos   = list_len;
        grows = 1'b1;
      end
      FN_POP_FRONT: shrinks = 1'b1;
      // On an empty list this position is negative and fails the range test.
      FN_POP_BACK: begin
        pos     = list_len - 1;
        shrinks = 1'b1;
      end
      FN_CLEAR: list_len = 0;
      default: ;
    endcase
    res.status = ST_OK;
    if (grows) begin
      // A bad index wins over a full list.
      if (pos > list_len) begin
        res.status = ST_BAD;
      end else if (list_len >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
        list_mem[pos] = '{weight: req.entry_weight, color: req.entry_color,
                          charge: req.entry_charge};
        list_len++;
      end
    end else if (shrinks || peeks) begin
      if (list_len == 0 || pos < 0 || pos >= list_len) begin
        res.status = ST_BAD;
      end else begin
        res.out_weight = list_mem[pos].weight;
        res.out_color  = list_mem[pos].color;
        res.out_charge = list_mem[pos].charge;
        if (shrinks) begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
    end
    res.list_count = COUNT_W'(list_len);
  endtask

  task automatic compare_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", field_name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_rd      = 0;
      pend_wr      = 0;
      pend_cnt     = 0;
      list_len     = 0;
      fail_count_o = 0;
      pending_o    = 0;
      list_len_o   = 0;
    end else begin
      // Results are checked before the request of the same edge is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (pend_cnt == 0) begin
          $error("result transaction with no request outstanding");
          fail_count_o++;
        end else begin
          oldest_result = pend_mem[pend_rd];
          pend_rd       = (pend_rd + 1) % PEND_DEPTH;
          pend_cnt--;
          compare_field("status", 32'(oldest_result.status), 32'(out_data_i.status));
          compare_field("out_weight", oldest_result.out_weight, out_data_i.out_weight);
          compare_field("out_color", 32'(oldest_result.out_color),
                        32'(out_data_i.out_color));
          compare_field("out_charge", oldest_result.out_charge, out_data_i.out_charge);
          compare_field("list_count", 32'(oldest_result.list_count),
                        32'(out_data_i.list_count));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_list_request(in_data_i, new_result);
        if (pend_cnt == PEND_DEPTH) begin
          $error("too many request transactions outstanding");
          fail_count_o++;
        end else begin
          pend_mem[pend_wr] = new_result;
          pend_wr           = (pend_wr + 1) % PEND_DEPTH;
          pend_cnt++;
        end
      end
      pending_o  = pend_cnt;
      list_len_o = list_len;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Indexed shift list testbench
// Drives directed corner requests and then a long random run that fills the
// list to its limit and churns it, with random idle bursts on both sides
// and one long result hold-off. The checker beside the block judges every
// result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import isl_pkg::*; ();

  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1400;
  localparam int GROW_ITEMS   = 1200;
  localparam int QUIET_FROM   = 1250;

  typedef enum int {
    GEN_FIXED,
    GEN_GROW,
    GEN_MIX
  } gen_mode_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic req_valid = 1'b0;
  in_t  req_data  = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  out_t rsp_data;
  int   fail_count;
  int   pending;
  int   list_len;
  bit   tail_quiet = 1'b0;
  int   gap_pct    = 0;

  indexed_shift_list_core #(
    .DEPTH (LIST_DEPTH)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp_data)
  );

  isl_list_checker #(
    .DEPTH (LIST_DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_stall_i   (req_stall),
    .in_data_i    (req_data),
    .out_valid_i  (rsp_valid),
    .out_stall_i  (rsp_stall),
    .out_data_i   (rsp_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  function automatic in_t list_request(input func_e f, input int idx,
                                       input logic [31:0] w, input logic [7:0] c,
                                       input logic [31:0] q);
    in_t r;
    r.func         = f;
    r.entry_index  = INDEX_W'(idx);
    r.entry_weight = w;
    r.entry_color  = c;
    r.entry_charge = q;
    return r;
  endfunction

  // Growth mode fills the list toward its limit; mix mode churns it.
  function automatic in_t random_request(input gen_mode_e mode, input int len);
    int   r;
    int   last;
    in_t  req;
    req = list_request(FN_READ_AT, 0, $urandom, 8'($urandom_range(0, 255)), $urandom);
    req.entry_index = INDEX_W'($urandom);
    last = (len > 0) ? len - 1 : 0;
    r = $urandom_range(0, 99);
    if (mode == GEN_GROW) begin
      if (r < 45) begin
        req.func = FN_INSERT_AT;
        req.entry_index = ($urandom_range(0, 19) == 0) ? INDEX_W'(len + 1) :
                                                         INDEX_W'($urandom_range(0, len));
      end else if (r < 70) begin
        req.func = FN_PUSH_BACK;
      end else if (r < 92) begin
        req.func = FN_PUSH_FRONT;
      end else if (r < 96) begin
        req.entry_index = INDEX_W'($urandom_range(0, last));
      end else begin
        req.func = func_e'($urandom_range(0, 6));
      end
    end else begin
      if (r < 20) begin
        req.func = FN_INSERT_AT;
        req.entry_index = INDEX_W'($urandom_range(0, len));
      end else if (r < 28) begin
        req.func = FN_PUSH_BACK;
      end else if (r < 35) begin
        req.func = FN_PUSH_FRONT;
      end else if (r < 50) begin
        req.func = FN_REMOVE_AT;
        req.entry_index = INDEX_W'($urandom_range(0, last));
      end else if (r < 60) begin
        req.func = FN_POP_FRONT;
      end else if (r < 70) begin
        req.func = FN_POP_BACK;
      end else if (r < 88) begin
        req.entry_index = INDEX_W'($urandom_range(0, last));
      end else if (r < 97) begin
        req.func = func_e'($urandom_range(0, 7));
      end else begin
        req.func = FN_CLEAR;
      end
    end
    return req;
  endfunction

  // The request is built at the falling edge so that the list length seen
  // already includes every earlier transaction.
  task automatic offer(input gen_mode_e mode, input in_t fixed);
    int  gap;
    in_t req;
    @(negedge clk);
    if (!tail_quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = (mode == GEN_FIXED) ? fixed : random_request(mode, list_len);
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (req_stall);
  endtask

  initial begin
    int burst;
    int stall_pct;
    int tick;
    bit held;
    burst     = 0;
    stall_pct = 0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 97 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 25;
        endcase
      end
      if (tail_quiet) begin
        rsp_stall <= 1'b0;
      end else if (!held && list_len >= 100) begin
        // One long hold-off while requests keep coming, so the block backs up.
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else if (burst > 0) begin
        burst--;
        rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(0, 11);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    int n;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gap_pct = 30;

    // Every failing request on an empty list, then a few entries at the ends.
    offer(GEN_FIXED, list_request(FN_POP_FRONT, 0, 32'h1, 8'h1, 32'h1));
    offer(GEN_FIXED, list_request(FN_POP_BACK, 2047, 32'h2, 8'h2, 32'h2));
    offer(GEN_FIXED, list_request(FN_READ_AT, 0, 32'h3, 8'h3, 32'h3));
    offer(GEN_FIXED, list_request(FN_REMOVE_AT, 0, 32'h4, 8'h4, 32'h4));
    offer(GEN_FIXED, list_request(FN_INSERT_AT, 1, 32'h5, 8'h5, 32'h5));
    offer(GEN_FIXED, list_request(FN_INSERT_AT, 0, 32'h7fffffff, 8'hff, 32'h80000000));
    offer(GEN_FIXED, list_request(FN_PUSH_BACK, 1024, 32'h80000000, 8'h00, 32'h7fffffff));
    offer(GEN_FIXED, list_request(FN_PUSH_FRONT, 2047, 32'hffffffff, 8'h80, 32'hffffffff));
    offer(GEN_FIXED, list_request(FN_INSERT_AT, 3, 32'h0, 8'h7f, 32'h0));
    offer(GEN_FIXED, list_request(FN_INSERT_AT, 2, 32'h12345678, 8'h5a, 32'hdeadbeef));
    offer(GEN_FIXED, list_request(FN_READ_AT, 0, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_READ_AT, 4, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_READ_AT, 5, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_READ_AT, 2047, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_REMOVE_AT, 1024, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_REMOVE_AT, 1, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_POP_FRONT, 0, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_POP_BACK, 0, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_CLEAR, 0, 32'h0, 8'h0, 32'h0));
    // The stores keep stale entries after a clear; none may be read back.
    offer(GEN_FIXED, list_request(FN_READ_AT, 0, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_CLEAR, 0, 32'h0, 8'h0, 32'h0));
    offer(GEN_FIXED, list_request(FN_PUSH_BACK, 0, 32'h55aa55aa, 8'h3c, 32'haa55aa55));
    offer(GEN_FIXED, list_request(FN_POP_BACK, 0, 32'h0, 8'h0, 32'h0));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 35;
        endcase
      end
      if (n == QUIET_FROM) tail_quiet = 1'b1;
      offer((n < GROW_ITEMS) ? GEN_GROW : GEN_MIX, '0);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
